// ===== hw/rtl/pti_pkg.sv =====
// ----------------------------------------------------------------------------
// pti_pkg
// Shared types, codes and constants of the piecewise table interpolator.
// ----------------------------------------------------------------------------
package pti_pkg;

  localparam int MAX_POINTS  = 256;
  localparam int MAX_REGIONS = 16;
  localparam int PT_AW       = $clog2(MAX_POINTS);
  localparam int RG_AW       = $clog2(MAX_REGIONS);
  localparam int Q_FRAC      = 16;
  localparam int LG_W        = 21;
  localparam int EXP_STEPS   = 16;
  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  typedef enum logic [1:0] {
    OP_LOAD_POINT  = 2'd0,
    OP_LOAD_REGION = 2'd1,
    OP_EVALUATE    = 2'd2,
    OP_UNUSED      = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_LOADED  = 3'd0,
    ST_INTERP  = 3'd1,
    ST_BELOW   = 3'd2,
    ST_ABOVE   = 3'd3,
    ST_BADCODE = 3'd4,
    ST_LOGDOM  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    SCH_HIST   = 3'd0,
    SCH_LINLIN = 3'd1,
    SCH_LINLOG = 3'd2,
    SCH_LOGLIN = 3'd3,
    SCH_LOGLOG = 3'd4
  } scheme_t;

  typedef enum logic [1:0] {
    AOP_LG    = 2'd0,
    AOP_RATIO = 2'd1,
    AOP_BLEND = 2'd2,
    AOP_EXP   = 2'd3
  } aop_t;

  typedef struct packed {
    logic start;
    aop_t op;
  } arith_req_t;

  typedef enum logic [2:0] {
    AR_IDLE, AR_NORM, AR_SQR, AR_DIV, AR_MUL, AR_ADD, AR_EXP, AR_FIN
  } arith_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHKFIRST, S_CHKLAST, S_SADDR, S_SCMP, S_RADDR, S_RCMP,
    S_RD0, S_RD1, S_GOT, S_LGX, S_LGX0, S_LGX1, S_DIV, S_LGY0, S_LGY1,
    S_BLEND, S_EXP, S_EMIT
  } seq_state_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } point_t;

  typedef struct packed {
    logic [8:0] limit;
    scheme_t    scheme;
  } region_t;

  typedef logic [EXP_STEPS-1:0][31:0] exp_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = n;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Q1.31 values of 2^(2^-k), k = 1..16
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] c;
    c = 64'd1 << 32;
    for (int k = 0; k < EXP_STEPS; k++) begin
      c      = isqrt64(c << 31);
      tab[k] = c[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

// ===== hw/rtl/pti_table.sv =====
// ----------------------------------------------------------------------------
// pti_table
// Point and region memories, one write and one registered read port each.
// ----------------------------------------------------------------------------
module pti_table (
  input  logic                        clk,
  input  logic                        pt_we,
  input  logic [pti_pkg::PT_AW-1:0]   pt_waddr,
  input  pti_pkg::point_t             pt_wdata,
  input  logic [pti_pkg::PT_AW-1:0]   pt_raddr,
  output pti_pkg::point_t             pt_rdata,
  input  logic                        rg_we,
  input  logic [pti_pkg::RG_AW-1:0]   rg_waddr,
  input  pti_pkg::region_t            rg_wdata,
  input  logic [pti_pkg::RG_AW-1:0]   rg_raddr,
  output pti_pkg::region_t            rg_rdata
);

  pti_pkg::point_t  pt_mem [pti_pkg::MAX_POINTS];
  pti_pkg::region_t rg_mem [pti_pkg::MAX_REGIONS];
  pti_pkg::point_t  pt_rdata_r;
  pti_pkg::region_t rg_rdata_r;

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata_r <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (rg_we) begin
      rg_mem[rg_waddr] <= rg_wdata;
    end
    rg_rdata_r <= rg_mem[rg_raddr];
  end

  assign pt_rdata = pt_rdata_r;
  assign rg_rdata = rg_rdata_r;

endmodule

// ===== hw/rtl/pti_arith.sv =====
// ----------------------------------------------------------------------------
// pti_arith
// Iterative arithmetic unit: log2, ratio divide, blend and exp2 around one
// shared 32x32 multiplier.
// ----------------------------------------------------------------------------
module pti_arith (
  input  logic                clk,
  input  logic                rst_n,
  input  pti_pkg::arith_req_t req,
  input  logic [31:0]         opa,
  input  logic [31:0]         opb,
  input  logic [31:0]         opc,
  output logic                done,
  output logic [31:0]         result
);

  localparam int NORM_STEPS = $clog2(32);

  pti_pkg::arith_state_t st_r, st_nxt;
  logic                  done_r, done_nxt;
  logic [31:0]           m_r, m_nxt;
  logic [4:0]            e_r, e_nxt;
  logic [15:0]           frac_r, frac_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic [31:0]           rem_r, rem_nxt;
  logic [31:0]           d_r, d_nxt;
  logic [15:0]           q_r, q_nxt;
  logic [31:0]           p0_r, p0_nxt;
  logic                  neg_r, neg_nxt;
  logic [16:0]           r_r, r_nxt;
  logic [63:0]           prod_r, prod_nxt;
  logic [pti_pkg::LG_W-1:0] t_r, t_nxt;
  logic [31:0]           res_r, res_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [32:0] sq;
  logic [5:0]  norm_sh;
  logic        norm_zero;
  logic [32:0] rem2;
  logic        ge;
  logic [31:0] sc;

  always_comb begin
    case (st_r)
      pti_pkg::AR_MUL: begin
        mul_a = m_r;
        mul_b = {15'd0, r_r};
      end
      pti_pkg::AR_EXP: begin
        mul_a = m_r;
        mul_b = pti_pkg::EXP_TAB[cnt_r[3:0]];
      end
      default: begin
        mul_a = m_r;
        mul_b = m_r;
      end
    endcase
  end

  assign mul_p     = {32'd0, mul_a} * {32'd0, mul_b};
  assign sq        = mul_p[63:31];
  assign norm_sh   = 6'd16 >> cnt_r[2:0];
  assign norm_zero = (m_r >> (6'd32 - norm_sh)) == '0;
  assign rem2      = {rem_r, 1'b0};
  assign ge        = rem2 >= {1'b0, d_r};
  assign sc        = prod_r[47:16];

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    m_nxt    = m_r;
    e_nxt    = e_r;
    frac_nxt = frac_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    q_nxt    = q_r;
    p0_nxt   = p0_r;
    neg_nxt  = neg_r;
    r_nxt    = r_r;
    prod_nxt = prod_r;
    t_nxt    = t_r;
    res_nxt  = res_r;
    case (st_r)
      pti_pkg::AR_IDLE: begin
        if (req.start) begin
          case (req.op)
            pti_pkg::AOP_LG: begin
              m_nxt   = opa;
              e_nxt   = 5'd31;
              cnt_nxt = '0;
              st_nxt  = pti_pkg::AR_NORM;
            end
            pti_pkg::AOP_RATIO: begin
              if (opc <= opb || opa <= opb) begin
                res_nxt  = '0;
                done_nxt = 1'b1;
              end else if (opa >= opc) begin
                res_nxt  = pti_pkg::ONE_Q16;
                done_nxt = 1'b1;
              end else begin
                rem_nxt = opa - opb;
                d_nxt   = opc - opb;
                q_nxt   = '0;
                cnt_nxt = '0;
                st_nxt  = pti_pkg::AR_DIV;
              end
            end
            pti_pkg::AOP_BLEND: begin
              p0_nxt = opa;
              if (opb >= opa) begin
                m_nxt   = opb - opa;
                neg_nxt = 1'b0;
              end else begin
                m_nxt   = opa - opb;
                neg_nxt = 1'b1;
              end
              r_nxt  = opc[16:0];
              st_nxt = pti_pkg::AR_MUL;
            end
            default: begin
              t_nxt   = opa[pti_pkg::LG_W-1:0];
              m_nxt   = 32'h8000_0000;
              cnt_nxt = '0;
              st_nxt  = pti_pkg::AR_EXP;
            end
          endcase
        end
      end
      // leading-one search by halving shifts
      pti_pkg::AR_NORM: begin
        if (norm_zero) begin
          m_nxt = m_r << norm_sh;
          e_nxt = e_r - 5'(norm_sh);
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(NORM_STEPS - 1)) begin
          cnt_nxt = '0;
          st_nxt  = pti_pkg::AR_SQR;
        end
      end
      pti_pkg::AR_SQR: begin
        frac_nxt = {frac_r[14:0], sq[32]};
        m_nxt    = sq[32] ? sq[32:1] : sq[31:0];
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'(pti_pkg::Q_FRAC - 1)) begin
          res_nxt  = 32'({e_r, frac_nxt});
          done_nxt = 1'b1;
          st_nxt   = pti_pkg::AR_IDLE;
        end
      end
      pti_pkg::AR_DIV: begin
        rem_nxt = ge ? 32'(rem2 - {1'b0, d_r}) : rem2[31:0];
        q_nxt   = {q_r[14:0], ge};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(pti_pkg::Q_FRAC - 1)) begin
          res_nxt  = {16'd0, q_nxt};
          done_nxt = 1'b1;
          st_nxt   = pti_pkg::AR_IDLE;
        end
      end
      pti_pkg::AR_MUL: begin
        prod_nxt = mul_p;
        st_nxt   = pti_pkg::AR_ADD;
      end
      pti_pkg::AR_ADD: begin
        res_nxt  = neg_r ? (p0_r - sc) : (p0_r + sc);
        done_nxt = 1'b1;
        st_nxt   = pti_pkg::AR_IDLE;
      end
      pti_pkg::AR_EXP: begin
        // fraction bits msb first, one table factor per step
        if (t_r[4'd15 - cnt_r[3:0]]) begin
          m_nxt = mul_p[62:31];
        end
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(pti_pkg::EXP_STEPS - 1)) begin
          st_nxt = pti_pkg::AR_FIN;
        end
      end
      pti_pkg::AR_FIN: begin
        res_nxt  = m_r >> (5'd31 - t_r[pti_pkg::LG_W-1:pti_pkg::Q_FRAC]);
        done_nxt = 1'b1;
        st_nxt   = pti_pkg::AR_IDLE;
      end
      default: begin
        st_nxt = pti_pkg::AR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= pti_pkg::AR_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    p0_r   <= p0_nxt;
    neg_r  <= neg_nxt;
    r_r    <= r_nxt;
    prod_r <= prod_nxt;
    t_r    <= t_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== hw/rtl/piecewise_table_interpolator.sv =====
// A load passes from its input beat to the result beat through the S_EMIT
// state. An evaluate runs a binary search (states S_SADDR and S_SCMP per
// probe through the point memory), a region scan, and the log2 and exp2
// steps in the shared arithmetic unit. One item is processed at a time; the
// next one is taken while a finished result waits in the output register.
// Synchronous active-low reset clears control; memories are not cleared.
// ----------------------------------------------------------------------------
// piecewise_table_interpolator
// Tabulated x,y interpolator with histogram, lin and log schemes per region.
// ----------------------------------------------------------------------------
module piecewise_table_interpolator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_slot,
  input  logic [31:0] in_abscissa,
  input  logic [31:0] in_ordinate,
  input  logic [8:0]  in_region_end,
  input  logic [4:0]  in_region_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_value,
  output logic [7:0]  out_bin,
  output logic [2:0]  out_status
);

  localparam logic CFG_PAIR_COUNT   = 1'b0;
  localparam logic CFG_REGION_COUNT = 1'b1;

  localparam logic [4:0] CODE_A_LO = 5'd1;
  localparam logic [4:0] CODE_A_HI = 5'd5;
  localparam logic [4:0] CODE_B_LO = 5'd11;
  localparam logic [4:0] CODE_B_HI = 5'd15;
  localparam logic [4:0] CODE_C_LO = 5'd21;
  localparam logic [4:0] CODE_C_HI = 5'd25;

  pti_pkg::seq_state_t state_r, state_nxt;
  logic [8:0]        pc_r, pc_nxt;
  logic [4:0]        rc_r, rc_nxt;
  logic [31:0]       x_r, x_nxt;
  logic [31:0]       x0_r, x0_nxt;
  logic [31:0]       x1_r, x1_nxt;
  logic [31:0]       y0_r, y0_nxt;
  logic [31:0]       y1_r, y1_nxt;
  logic [7:0]        lo_r, lo_nxt;
  logic [7:0]        hi_r, hi_nxt;
  logic [7:0]        mid_r, mid_nxt;
  logic [4:0]        j_r, j_nxt;
  pti_pkg::scheme_t  sch_r, sch_nxt;
  logic [16:0]       r_r, r_nxt;
  logic              wait_r, wait_nxt;
  logic [31:0]       res_value_r, res_value_nxt;
  logic [7:0]        res_bin_r, res_bin_nxt;
  pti_pkg::status_t  res_status_r, res_status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       out_value_r, out_value_nxt;
  logic [7:0]        out_bin_r, out_bin_nxt;
  pti_pkg::status_t  out_status_r, out_status_nxt;

  logic [8:0]  n_eff;
  logic [4:0]  rc_eff;
  logic        accept;
  logic        code_ok;
  logic [2:0]  code_sch;
  logic        xlog, ylog, dom_err;
  logic [8:0]  mid_sum;

  logic                          pt_we, rg_we;
  pti_pkg::point_t               pt_wdata, pt_rdata;
  pti_pkg::region_t              rg_wdata, rg_rdata;
  logic [pti_pkg::PT_AW-1:0]     pt_raddr;

  pti_pkg::arith_req_t areq;
  logic [31:0]         aopa, aopb, aopc, ares;
  logic                adone;

  assign n_eff  = (pc_r < 9'd2) ? 9'd2 :
                  (pc_r > 9'(pti_pkg::MAX_POINTS)) ? 9'(pti_pkg::MAX_POINTS) : pc_r;
  assign rc_eff = (rc_r > 5'(pti_pkg::MAX_REGIONS)) ? 5'(pti_pkg::MAX_REGIONS) : rc_r;

  assign in_ready = (state_r == pti_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    code_ok  = 1'b1;
    code_sch = '0;
    if (in_region_code inside {[CODE_C_LO:CODE_C_HI]}) begin
      code_sch = 3'(in_region_code - CODE_C_LO);
    end else if (in_region_code inside {[CODE_B_LO:CODE_B_HI]}) begin
      code_sch = 3'(in_region_code - CODE_B_LO);
    end else if (in_region_code inside {[CODE_A_LO:CODE_A_HI]}) begin
      code_sch = 3'(in_region_code - CODE_A_LO);
    end else begin
      code_ok = 1'b0;
    end
  end

  assign pt_we = accept && (in_operation == pti_pkg::OP_LOAD_POINT)
                 && (int'(in_slot) < pti_pkg::MAX_POINTS);
  assign rg_we = accept && (in_operation == pti_pkg::OP_LOAD_REGION) && code_ok
                 && (int'(in_slot) < pti_pkg::MAX_REGIONS);
  assign pt_wdata.x      = in_abscissa;
  assign pt_wdata.y      = in_ordinate;
  assign rg_wdata.limit  = in_region_end - 9'd1;
  assign rg_wdata.scheme = pti_pkg::scheme_t'(code_sch);

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};

  always_comb begin
    case (state_r)
      pti_pkg::S_CHKFIRST: pt_raddr = n_eff[pti_pkg::PT_AW-1:0] - 8'd1;
      pti_pkg::S_SADDR:    pt_raddr = mid_sum[pti_pkg::PT_AW:1];
      pti_pkg::S_RD0:      pt_raddr = lo_r;
      pti_pkg::S_RD1:      pt_raddr = lo_r + 8'd1;
      default:             pt_raddr = '0;
    endcase
  end

  pti_table u_table (
    .clk      (clk),
    .pt_we    (pt_we),
    .pt_waddr (in_slot[pti_pkg::PT_AW-1:0]),
    .pt_wdata (pt_wdata),
    .pt_raddr (pt_raddr),
    .pt_rdata (pt_rdata),
    .rg_we    (rg_we),
    .rg_waddr (in_slot[pti_pkg::RG_AW-1:0]),
    .rg_wdata (rg_wdata),
    .rg_raddr (j_r[pti_pkg::RG_AW-1:0]),
    .rg_rdata (rg_rdata)
  );

  assign xlog = (sch_r == pti_pkg::SCH_LINLOG) || (sch_r == pti_pkg::SCH_LOGLOG);
  assign ylog = (sch_r == pti_pkg::SCH_LOGLIN) || (sch_r == pti_pkg::SCH_LOGLOG);
  assign dom_err = (xlog && (x_r == '0 || x0_r == '0 || pt_rdata.x == '0)) ||
                   (ylog && (y0_r == '0 || pt_rdata.y == '0));

  // operand select for the arithmetic unit
  always_comb begin
    areq.start = 1'b0;
    areq.op    = pti_pkg::AOP_LG;
    aopa       = '0;
    aopb       = '0;
    aopc       = '0;
    case (state_r)
      pti_pkg::S_LGX:  aopa = x_r;
      pti_pkg::S_LGX0: aopa = x0_r;
      pti_pkg::S_LGX1: aopa = x1_r;
      pti_pkg::S_LGY0: aopa = y0_r;
      pti_pkg::S_LGY1: aopa = y1_r;
      pti_pkg::S_DIV: begin
        areq.op = pti_pkg::AOP_RATIO;
        aopa    = x_r;
        aopb    = x0_r;
        aopc    = x1_r;
      end
      pti_pkg::S_BLEND: begin
        areq.op = pti_pkg::AOP_BLEND;
        aopa    = y0_r;
        aopb    = y1_r;
        aopc    = {15'd0, r_r};
      end
      pti_pkg::S_EXP: begin
        areq.op = pti_pkg::AOP_EXP;
        aopa    = res_value_r;
      end
      default: ;
    endcase
    if (state_r inside {pti_pkg::S_LGX, pti_pkg::S_LGX0, pti_pkg::S_LGX1,
                        pti_pkg::S_DIV, pti_pkg::S_LGY0, pti_pkg::S_LGY1,
                        pti_pkg::S_BLEND, pti_pkg::S_EXP}) begin
      areq.start = !wait_r;
    end
  end

  pti_arith u_arith (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (areq),
    .opa    (aopa),
    .opb    (aopb),
    .opc    (aopc),
    .done   (adone),
    .result (ares)
  );

  always_comb begin
    state_nxt      = state_r;
    pc_nxt         = pc_r;
    rc_nxt         = rc_r;
    x_nxt          = x_r;
    x0_nxt         = x0_r;
    x1_nxt         = x1_r;
    y0_nxt         = y0_r;
    y1_nxt         = y1_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    j_nxt          = j_r;
    sch_nxt        = sch_r;
    r_nxt          = r_r;
    wait_nxt       = wait_r;
    res_value_nxt  = res_value_r;
    res_bin_nxt    = res_bin_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_bin_nxt    = out_bin_r;
    out_status_nxt = out_status_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_PAIR_COUNT:   pc_nxt = cfg_data;
        CFG_REGION_COUNT: rc_nxt = cfg_data[4:0];
        default: ;
      endcase
    end

    if (areq.start) begin
      wait_nxt = 1'b1;
    end
    if (adone) begin
      wait_nxt = 1'b0;
    end

    case (state_r)
      pti_pkg::S_IDLE: begin
        if (accept) begin
          x_nxt          = in_abscissa;
          res_value_nxt  = '0;
          res_bin_nxt    = '0;
          res_status_nxt = pti_pkg::ST_LOADED;
          state_nxt      = pti_pkg::S_EMIT;
          case (in_operation)
            pti_pkg::OP_LOAD_REGION: begin
              if (!code_ok) begin
                res_status_nxt = pti_pkg::ST_BADCODE;
              end
            end
            pti_pkg::OP_EVALUATE: state_nxt = pti_pkg::S_CHKFIRST;
            default: ;
          endcase
        end
      end
      pti_pkg::S_CHKFIRST: begin
        if (x_r < pt_rdata.x) begin
          res_value_nxt  = pt_rdata.y;
          res_bin_nxt    = '0;
          res_status_nxt = pti_pkg::ST_BELOW;
          state_nxt      = pti_pkg::S_EMIT;
        end else begin
          state_nxt = pti_pkg::S_CHKLAST;
        end
      end
      pti_pkg::S_CHKLAST: begin
        if (x_r > pt_rdata.x) begin
          res_value_nxt  = pt_rdata.y;
          res_bin_nxt    = 8'(n_eff - 9'd2);
          res_status_nxt = pti_pkg::ST_ABOVE;
          state_nxt      = pti_pkg::S_EMIT;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = 8'(n_eff - 9'd1);
          state_nxt = pti_pkg::S_SADDR;
        end
      end
      pti_pkg::S_SADDR: begin
        if (hi_r - lo_r > 8'd1) begin
          mid_nxt   = mid_sum[8:1];
          state_nxt = pti_pkg::S_SCMP;
        end else if (rc_eff == '0) begin
          sch_nxt   = pti_pkg::SCH_LINLIN;
          state_nxt = pti_pkg::S_RD0;
        end else begin
          j_nxt     = '0;
          state_nxt = pti_pkg::S_RADDR;
        end
      end
      pti_pkg::S_SCMP: begin
        if (pt_rdata.x < x_r) begin
          lo_nxt = mid_r;
        end else begin
          hi_nxt = mid_r;
        end
        state_nxt = pti_pkg::S_SADDR;
      end
      pti_pkg::S_RADDR: state_nxt = pti_pkg::S_RCMP;
      pti_pkg::S_RCMP: begin
        // first region wins; region zero's scheme when none matches
        if (j_r == '0 || {1'b0, lo_r} < rg_rdata.limit) begin
          sch_nxt = rg_rdata.scheme;
        end
        if ({1'b0, lo_r} < rg_rdata.limit || j_r + 5'd1 == rc_eff) begin
          state_nxt = pti_pkg::S_RD0;
        end else begin
          j_nxt     = j_r + 5'd1;
          state_nxt = pti_pkg::S_RADDR;
        end
      end
      pti_pkg::S_RD0: state_nxt = pti_pkg::S_RD1;
      pti_pkg::S_RD1: begin
        x0_nxt    = pt_rdata.x;
        y0_nxt    = pt_rdata.y;
        state_nxt = pti_pkg::S_GOT;
      end
      pti_pkg::S_GOT: begin
        x1_nxt         = pt_rdata.x;
        y1_nxt         = pt_rdata.y;
        res_bin_nxt    = lo_r;
        res_status_nxt = pti_pkg::ST_INTERP;
        if (sch_r == pti_pkg::SCH_HIST) begin
          res_value_nxt = y0_r;
          state_nxt     = pti_pkg::S_EMIT;
        end else if (dom_err) begin
          res_value_nxt  = '0;
          res_status_nxt = pti_pkg::ST_LOGDOM;
          state_nxt      = pti_pkg::S_EMIT;
        end else begin
          state_nxt = xlog ? pti_pkg::S_LGX : pti_pkg::S_DIV;
        end
      end
      pti_pkg::S_LGX: begin
        if (adone) begin
          x_nxt     = ares;
          state_nxt = pti_pkg::S_LGX0;
        end
      end
      pti_pkg::S_LGX0: begin
        if (adone) begin
          x0_nxt    = ares;
          state_nxt = pti_pkg::S_LGX1;
        end
      end
      pti_pkg::S_LGX1: begin
        if (adone) begin
          x1_nxt    = ares;
          state_nxt = pti_pkg::S_DIV;
        end
      end
      pti_pkg::S_DIV: begin
        if (adone) begin
          r_nxt     = ares[16:0];
          state_nxt = ylog ? pti_pkg::S_LGY0 : pti_pkg::S_BLEND;
        end
      end
      pti_pkg::S_LGY0: begin
        if (adone) begin
          y0_nxt    = ares;
          state_nxt = pti_pkg::S_LGY1;
        end
      end
      pti_pkg::S_LGY1: begin
        if (adone) begin
          y1_nxt    = ares;
          state_nxt = pti_pkg::S_BLEND;
        end
      end
      pti_pkg::S_BLEND: begin
        if (adone) begin
          res_value_nxt = ares;
          state_nxt     = ylog ? pti_pkg::S_EXP : pti_pkg::S_EMIT;
        end
      end
      pti_pkg::S_EXP: begin
        if (adone) begin
          res_value_nxt = ares;
          state_nxt     = pti_pkg::S_EMIT;
        end
      end
      pti_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_bin_nxt    = res_bin_r;
          out_status_nxt = res_status_r;
          state_nxt      = pti_pkg::S_IDLE;
        end
      end
      default: state_nxt = pti_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pti_pkg::S_IDLE;
      pc_r        <= 9'd2;
      rc_r        <= '0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      rc_r        <= rc_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r          <= x_nxt;
    x0_r         <= x0_nxt;
    x1_r         <= x1_nxt;
    y0_r         <= y0_nxt;
    y1_r         <= y1_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    j_r          <= j_nxt;
    sch_r        <= sch_nxt;
    r_r          <= r_nxt;
    res_value_r  <= res_value_nxt;
    res_bin_r    <= res_bin_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_bin_r    <= out_bin_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_bin    = out_bin_r;
  assign out_status = out_status_r;

endmodule

// ===== hw/rtl/pti_checker.sv =====
// ----------------------------------------------------------------------------
// pti_checker
// Port-level checks of the interpolator, bound to the top level.
// ----------------------------------------------------------------------------
module pti_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_value,
  input logic [7:0]  out_bin,
  input logic [2:0]  out_status
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status)
      && $stable(out_bin))
    else $error("result beat changed while stalled");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'(pti_pkg::ST_LOGDOM))
    else $error("status out of range");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(pti_pkg::ST_LOADED) || out_status == 3'(pti_pkg::ST_BADCODE)
      || out_status == 3'(pti_pkg::ST_LOGDOM)) |-> out_value == '0)
    else $error("nonzero value on load or error");

  a_zero_bin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == 3'(pti_pkg::ST_LOADED) || out_status == 3'(pti_pkg::ST_BADCODE)
      || out_status == 3'(pti_pkg::ST_BELOW)) |-> out_bin == '0)
    else $error("nonzero bin on load or below range");

endmodule

bind piecewise_table_interpolator pti_checker u_pti_checker (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the table interpolator with point loads, region loads and
// evaluations under several table sizes and region counts. A local fixed
// point predictor computes every result, and the results are compared in
// order.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    pti_pkg::op_t op;
    logic [7:0]   slot;
    logic [31:0]  x;
    logic [31:0]  y;
    logic [8:0]   rend;
    logic [4:0]   code;
  } beat_t;

  typedef struct {
    logic [31:0]      value;
    logic [7:0]       bin;
    pti_pkg::status_t status;
  } outcome_t;

  logic        clk, rst_n;
  logic        cfg_we, cfg_index;
  logic [8:0]  cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  in_operation;
  logic [7:0]  in_slot;
  logic [31:0] in_abscissa, in_ordinate;
  logic [8:0]  in_region_end;
  logic [4:0]  in_region_code;
  logic        out_valid, out_ready;
  logic [31:0] out_value;
  logic [7:0]  out_bin;
  logic [2:0]  out_status;

  piecewise_table_interpolator dut (.*);

  // predictor state
  logic [31:0]      tab_x [pti_pkg::MAX_POINTS];
  logic [31:0]      tab_y [pti_pkg::MAX_POINTS];
  logic [8:0]       reg_lim [pti_pkg::MAX_REGIONS];
  pti_pkg::scheme_t reg_sch [pti_pkg::MAX_REGIONS];
  logic [8:0]       pairs_cfg;
  logic [4:0]       regions_cfg;
  logic [63:0]      root_tab [1:16];

  beat_t    pending_q[$];
  outcome_t expected_q[$];
  int       errors;
  int       idle_mode;
  int       cycles;
  logic     beat_in;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] int_sqrt(logic [63:0] n);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] log2_q(logic [31:0] v);
    int          e;
    logic [63:0] m, frac;
    e = 31;
    frac = 0;
    while (e > 0 && !v[e]) e--;
    m = {32'd0, v} << (31 - e);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        frac[0] = 1'b1;
        m = m >> 1;
      end
    end
    return (64'(e) << 16) | frac;
  endfunction

  function automatic logic [31:0] exp2_q(logic [63:0] t);
    logic [63:0] m;
    m = 64'd1 << 31;
    for (int k = 1; k <= 16; k++)
      if (t[16-k]) m = (m * root_tab[k]) >> 31;
    m = m >> (31 - t[20:16]);
    return m[31:0];
  endfunction

  function automatic logic [63:0] frac_pos(logic [63:0] a, logic [63:0] a0, logic [63:0] a1);
    if (a1 <= a0 || a <= a0) return 0;
    if (a >= a1) return 64'd65536;
    return ((a - a0) << 16) / (a1 - a0);
  endfunction

  function automatic logic [63:0] mix(logic [63:0] p0, logic [63:0] p1, logic [63:0] r);
    if (p1 >= p0) return p0 + (((p1 - p0) * r) >> 16);
    return p0 - (((p0 - p1) * r) >> 16);
  endfunction

  function automatic outcome_t interpolate(logic [31:0] x);
    outcome_t         o;
    int               n, rc, lo, hi, mid;
    pti_pkg::scheme_t sch;
    logic [31:0]      x0, x1, y0, y1;
    logic [63:0]      r;
    n = pairs_cfg < 2 ? 2 :
        (pairs_cfg > pti_pkg::MAX_POINTS ? pti_pkg::MAX_POINTS : pairs_cfg);
    rc = regions_cfg > pti_pkg::MAX_REGIONS ? pti_pkg::MAX_REGIONS : regions_cfg;
    o.bin = 0;
    o.value = 0;
    if (x < tab_x[0]) begin
      o.value = tab_y[0];
      o.status = pti_pkg::ST_BELOW;
      return o;
    end
    if (x > tab_x[n-1]) begin
      o.value = tab_y[n-1];
      o.bin = 8'(n - 2);
      o.status = pti_pkg::ST_ABOVE;
      return o;
    end
    lo = 0;
    hi = n - 1;
    while (hi - lo > 1) begin
      mid = (lo + hi) / 2;
      if (tab_x[mid] < x) lo = mid;
      else hi = mid;
    end
    o.bin = 8'(lo);
    sch = pti_pkg::SCH_LINLIN;
    if (rc != 0) begin
      sch = reg_sch[0];
      for (int j = 0; j < rc; j++)
        if (lo < reg_lim[j]) begin
          sch = reg_sch[j];
          break;
        end
    end
    x0 = tab_x[lo];
    x1 = tab_x[lo+1];
    y0 = tab_y[lo];
    y1 = tab_y[lo+1];
    o.status = pti_pkg::ST_INTERP;
    if (sch == pti_pkg::SCH_HIST) begin
      o.value = y0;
      return o;
    end
    if (sch == pti_pkg::SCH_LINLOG || sch == pti_pkg::SCH_LOGLOG) begin
      if (x == 0 || x0 == 0 || x1 == 0) begin
        o.status = pti_pkg::ST_LOGDOM;
        return o;
      end
      r = frac_pos(log2_q(x), log2_q(x0), log2_q(x1));
    end else begin
      r = frac_pos(x, x0, x1);
    end
    if (sch == pti_pkg::SCH_LOGLIN || sch == pti_pkg::SCH_LOGLOG) begin
      if (y0 == 0 || y1 == 0) begin
        o.status = pti_pkg::ST_LOGDOM;
        return o;
      end
      o.value = exp2_q(mix(log2_q(y0), log2_q(y1), r));
    end else begin
      o.value = 32'(mix(y0, y1, r));
    end
    return o;
  endfunction

  function automatic outcome_t apply_beat(beat_t b);
    outcome_t o;
    int       base;
    o.value = 0;
    o.bin = 0;
    o.status = pti_pkg::ST_LOADED;
    case (b.op)
      pti_pkg::OP_LOAD_POINT: begin
        tab_x[b.slot] = b.x;
        tab_y[b.slot] = b.y;
      end
      pti_pkg::OP_LOAD_REGION: begin
        if (b.code >= 21 && b.code <= 25) base = 20;
        else if (b.code >= 11 && b.code <= 15) base = 10;
        else if (b.code >= 1 && b.code <= 5) base = 0;
        else base = -1;
        if (base < 0) o.status = pti_pkg::ST_BADCODE;
        else if (b.slot < pti_pkg::MAX_REGIONS) begin
          reg_lim[b.slot] = b.rend - 9'd1;
          reg_sch[b.slot] = pti_pkg::scheme_t'(b.code - base - 1);
        end
      end
      pti_pkg::OP_EVALUATE: o = interpolate(b.x);
      default: ;
    endcase
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // driver
  always @(negedge clk) begin
    logic  hold_off;
    beat_t b;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || beat_in) begin
      hold_off = idle_mode == 0 ? ($urandom_range(99) < 15) :
                 idle_mode == 1 ? ($urandom_range(99) < 48) : 1'b0;
      if (pending_q.size() > 0 && !hold_off) begin
        b = pending_q.pop_front();
        in_valid <= 1'b1;
        in_operation <= b.op;
        in_slot <= b.slot;
        in_abscissa <= b.x;
        in_ordinate <= b.y;
        in_region_end <= b.rend;
        in_region_code <= b.code;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= idle_mode == 0 ? ($urandom_range(99) >= 48) :
                 idle_mode == 1 ? ($urandom_range(99) >= 15) : 1'b1;
  end

  // input beats feed the predictor, output beats are checked
  always @(posedge clk) begin
    beat_t    b;
    outcome_t want;
    beat_in <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      b.op = pti_pkg::op_t'(in_operation);
      b.slot = in_slot;
      b.x = in_abscissa;
      b.y = in_ordinate;
      b.rend = in_region_end;
      b.code = in_region_code;
      expected_q.insert(expected_q.size(), apply_beat(b));
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected beat", out_value, '0);
      end else begin
        want = expected_q.pop_front();
        if (out_value !== want.value) report("value", out_value, want.value);
        if (out_bin !== want.bin) report("bin", 32'(out_bin), 32'(want.bin));
        if (out_status !== want.status)
          report("status", 32'(out_status), 32'(want.status));
      end
    end
    cycles++;
    if (cycles > 3000000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push(pti_pkg::op_t op, int slot, logic [31:0] x, logic [31:0] y,
                      int rend, int code);
    beat_t b;
    b.op = op;
    b.slot = 8'(slot);
    b.x = x;
    b.y = y;
    b.rend = 9'(rend);
    b.code = 5'(code);
    pending_q.insert(pending_q.size(), b);
  endtask

  function automatic logic [31:0] rand_y();
    int k;
    k = $urandom_range(9);
    if (k == 0) return 0;
    if (k < 4) return $urandom();
    return $urandom_range(32'h00FF_FFFF, 1);
  endfunction

  // sorted table with steps of random scale, saturating at the top
  task automatic queue_table(int cnt);
    logic [63:0] acc;
    int          sh;
    acc = $urandom_range(3) == 0 ? 0 : $urandom_range(32'h0004_0000);
    sh = $urandom_range(24, 4);
    for (int i = 0; i < cnt; i++) begin
      push(pti_pkg::OP_LOAD_POINT, i, acc > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : acc[31:0],
           rand_y(), 0, 0);
      acc += $urandom_range(7) == 0 ? 0 : $urandom_range(1 << sh, 1);
    end
  endtask

  task automatic queue_regions(int n);
    int e;
    e = 0;
    for (int j = 0; j < pti_pkg::MAX_REGIONS; j++) begin
      e = e + $urandom_range(n / 8 + 1, 1);
      push(pti_pkg::OP_LOAD_REGION, j, 0, 0, j == pti_pkg::MAX_REGIONS - 1 ? n : e,
           10 * $urandom_range(2) + $urandom_range(5, 1));
    end
  endtask

  function automatic logic [31:0] pick_x(int n);
    int          i;
    logic [31:0] b;
    i = $urandom_range(n - 1);
    b = tab_x[i];
    case ($urandom_range(7))
      0: return $urandom();
      1: return b;
      2: return b + 1;
      3: return b - 1;
      4: return $urandom_range(3) == 0 ? 32'h0 : 32'hFFFF_FFFF;
      default: return b + $urandom_range(tab_x[i+1 < n ? i+1 : i] - b);
    endcase
  endfunction

  task automatic queue_random(int cnt);
    int n, k;
    n = pairs_cfg < 2 ? 2 :
        (pairs_cfg > pti_pkg::MAX_POINTS ? pti_pkg::MAX_POINTS : pairs_cfg);
    for (int i = 0; i < cnt; i++) begin
      k = $urandom_range(99);
      if (k < 62) push(pti_pkg::OP_EVALUATE, $urandom_range(255), pick_x(n), $urandom(),
                       0, 0);
      else if (k < 76) push(pti_pkg::OP_LOAD_POINT, $urandom_range(255), $urandom(),
                            rand_y(), $urandom_range(511), $urandom_range(31));
      else if (k < 94) push(pti_pkg::OP_LOAD_REGION, $urandom_range(3) == 0 ?
                            $urandom_range(255) : $urandom_range(pti_pkg::MAX_REGIONS - 1),
                            $urandom(), $urandom(), $urandom_range(511),
                            $urandom_range(31));
      else push(pti_pkg::OP_UNUSED, $urandom_range(255), $urandom(), $urandom(),
                $urandom_range(511), $urandom_range(31));
    end
  endtask

  task automatic drain();
    do begin
      @(posedge clk);
      #1;
    end while (pending_q.size() != 0 || in_valid || expected_q.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_cfg(int pc, int rc);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= 1'b0;
    cfg_data <= 9'(pc);
    pairs_cfg = 9'(pc);
    @(negedge clk);
    cfg_index <= 1'b1;
    cfg_data <= 9'(rc);
    regions_cfg = 5'(rc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          pc_list [9];
    int          rc_list [9];
    logic [63:0] c;
    pc_list = '{2, 256, 5, 17, 0, 511, 3, 100, 256};
    rc_list = '{0, 16, 1, 3, 31, 4, 0, 16, 2};
    c = 64'd1 << 32;
    for (int k = 1; k <= 16; k++) begin
      c = int_sqrt(c << 31);
      root_tab[k] = c;
    end
    errors = 0;
    cycles = 0;
    idle_mode = 0;
    beat_in = 1'b0;
    pairs_cfg = 9'd2;
    regions_cfg = 5'd0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_operation = '0;
    in_slot = '0;
    in_abscissa = '0;
    in_ordinate = '0;
    in_region_end = '0;
    in_region_code = '0;
    out_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: two point table at reset settings
    push(pti_pkg::OP_LOAD_POINT, 0, 32'h0001_0000, 32'h0002_0000, 0, 0);
    push(pti_pkg::OP_LOAD_POINT, 1, 32'h0003_0000, 32'hFFFF_FFFF, 0, 0);
    push(pti_pkg::OP_EVALUATE, 0, 32'h0, 0, 0, 0);
    push(pti_pkg::OP_EVALUATE, 0, 32'hFFFF_FFFF, 0, 0, 0);
    push(pti_pkg::OP_EVALUATE, 0, 32'h0002_0000, 0, 0, 0);
    push(pti_pkg::OP_EVALUATE, 0, 32'h0001_0000, 0, 0, 0);
    push(pti_pkg::OP_EVALUATE, 0, 32'h0003_0000, 0, 0, 0);
    push(pti_pkg::OP_UNUSED, 255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 511, 31);
    push(pti_pkg::OP_LOAD_REGION, 0, 0, 0, 5, 0);
    push(pti_pkg::OP_LOAD_REGION, 0, 0, 0, 5, 31);
    push(pti_pkg::OP_LOAD_REGION, 0, 0, 0, 5, 6);
    push(pti_pkg::OP_LOAD_REGION, 3, 0, 0, 5, 16);
    push(pti_pkg::OP_LOAD_REGION, 200, 0, 0, 5, 2);
    push(pti_pkg::OP_LOAD_REGION, 255, 0, 0, 256, 25);
    push(pti_pkg::OP_LOAD_REGION, 0, 0, 0, 0, 1);
    push(pti_pkg::OP_LOAD_REGION, 1, 0, 0, 256, 25);
    push(pti_pkg::OP_LOAD_POINT, 1, 32'h0003_0000, 32'h0, 0, 0);
    push(pti_pkg::OP_EVALUATE, 0, 32'h0002_0000, 0, 0, 0);
    // fill the whole table so that every setting reads written entries only
    queue_table(pti_pkg::MAX_POINTS);
    queue_regions(pti_pkg::MAX_POINTS);
    drain();

    for (int p = 0; p < 9; p++) begin
      idle_mode = p / 3;
      write_cfg(pc_list[p], rc_list[p]);
      queue_table(pc_list[p] < 2 ? 2 : (pc_list[p] > 40 ? 40 : pc_list[p]));
      queue_regions(pc_list[p] < 2 ? 2 : (pc_list[p] > 256 ? 256 : pc_list[p]));
      drain();
      queue_random(115);
      drain();
    end

    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pti_pkg.sv
hw/rtl/pti_table.sv
hw/rtl/pti_arith.sv
hw/rtl/piecewise_table_interpolator.sv
hw/rtl/pti_checker.sv
dv/tb_top.sv
